/* design/arc_pkg.sv */
package arc_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int SLOT_W  = 3;
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int TICK_W  = 64;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_STORE  = 2'd1,
    KIND_FLUSH  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OUT_MISS     = 3'd0,
    OUT_HIT      = 3'd1,
    OUT_STALE    = 3'd2,
    OUT_UPDATED  = 3'd3,
    OUT_ADDED    = 3'd4,
    OUT_REPLACED = 3'd5,
    OUT_REJECTED = 3'd6,
    OUT_FLUSHED  = 3'd7
  } outcome_t;

  // controller -> datapath
  typedef struct packed {
    logic     load;
    logic     flush;
    logic     scan_clear;
    logic     scan_step;
    logic     write;
    logic     age;
    logic     emit;
    outcome_t outcome;
  } arc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  ip_zero;
    logic  hit_now;
    logic  last;
    logic  free_any;
    logic  stale;
    logic  out_free;
  } arc_stat_t;

  // slot number reported modulo 2^SLOT_W
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

/* design/arc_ctrl.sv */
module arc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  arc_pkg::arc_stat_t stat,
  output arc_pkg::arc_cmd_t  cmd
);
  import arc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECODE = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_AGE    = 7'b0001000,
    ST_CHECK  = 7'b0010000,
    ST_WRITE  = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  state_t   state_r, state_nxt;
  outcome_t outcome_r, outcome_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    outcome_nxt = outcome_r;
    cmd         = '0;
    cmd.outcome = outcome_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.kind == KIND_FLUSH) begin
          cmd.flush   = 1'b1;
          outcome_nxt = OUT_FLUSHED;
          state_nxt   = ST_EMIT;
        end else if (stat.kind == KIND_NONE) begin
          outcome_nxt = OUT_MISS;
          state_nxt   = ST_EMIT;
        end else if (stat.ip_zero) begin
          outcome_nxt = OUT_REJECTED;
          state_nxt   = ST_EMIT;
        end else begin
          cmd.scan_clear = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit_now) begin
          if (stat.kind == KIND_LOOKUP) begin
            state_nxt = ST_AGE;
          end else begin
            outcome_nxt = OUT_UPDATED;
            state_nxt   = ST_WRITE;
          end
        end else if (stat.last) begin
          if (stat.kind == KIND_LOOKUP) begin
            outcome_nxt = OUT_MISS;
            state_nxt   = ST_EMIT;
          end else begin
            outcome_nxt = stat.free_any ? OUT_ADDED : OUT_REPLACED;
            state_nxt   = ST_WRITE;
          end
        end
      end
      ST_AGE: begin
        cmd.age   = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        outcome_nxt = stat.stale ? OUT_STALE : OUT_HIT;
        state_nxt   = ST_EMIT;
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      outcome_r <= OUT_MISS;
    end else begin
      state_r   <= state_nxt;
      outcome_r <= outcome_nxt;
    end
  end

endmodule

/* design/arc_dp.sv */
module arc_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  arc_pkg::kind_t                      in_kind,
  input  logic [arc_pkg::IP_W-1:0]            in_ip,
  input  logic [arc_pkg::MAC_W-1:0]           in_mac,
  input  logic [arc_pkg::TICK_W-1:0]          in_now,
  input  logic [arc_pkg::TICK_W-1:0]          in_max_age,
  input  arc_pkg::arc_cmd_t                   cmd,
  output arc_pkg::arc_stat_t                  stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output arc_pkg::outcome_t                   out_outcome,
  output logic [arc_pkg::MAC_W-1:0]           out_mac,
  output logic [arc_pkg::SLOT_W-1:0]          out_slot
);
  import arc_pkg::*;

  // table
  logic [ENTRIES-1:0] valid_r;
  logic [IP_W-1:0]    ip_mem   [ENTRIES];
  logic [MAC_W-1:0]   mac_mem  [ENTRIES];
  logic [TICK_W-1:0]  stamp_mem[ENTRIES];

  // item being worked on
  kind_t              kind_r;
  logic [IP_W-1:0]    ip_r;
  logic [MAC_W-1:0]   mac_r;
  logic [TICK_W-1:0]  now_r;
  logic [TICK_W-1:0]  max_age_r;

  // scan state
  logic [IDX_W-1:0]   idx_r;
  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic               free_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic [TICK_W-1:0]  diff_r;

  // result register
  logic               out_valid_r;
  outcome_t           out_outcome_r;
  logic [MAC_W-1:0]   out_mac_r;
  logic [SLOT_W-1:0]  out_slot_r;

  logic               hit_now;
  logic [IDX_W-1:0]   wr_idx;
  logic [MAC_W-1:0]   res_mac;
  logic [SLOT_W-1:0]  res_slot;

  assign hit_now = valid_r[idx_r] && (ip_mem[idx_r] == ip_r);
  assign wr_idx  = hit_r ? hit_idx_r : (free_r ? free_idx_r : '0);

  always_comb begin
    stat.kind     = kind_r;
    stat.ip_zero  = (ip_r == '0);
    stat.hit_now  = hit_now;
    stat.last     = (idx_r == IDX_W'(ENTRIES - 1));
    stat.free_any = free_r || !valid_r[idx_r];
    stat.stale    = (max_age_r != '0) && (diff_r > max_age_r);
    stat.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    res_mac  = '0;
    res_slot = '0;
    case (cmd.outcome)
      OUT_HIT: begin
        res_mac  = mac_mem[hit_idx_r];
        res_slot = to_slot(hit_idx_r);
      end
      OUT_STALE, OUT_UPDATED: begin
        res_slot = to_slot(hit_idx_r);
      end
      OUT_ADDED: begin
        res_slot = to_slot(free_idx_r);
      end
      default: begin
        res_slot = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      ip_r      <= in_ip;
      mac_r     <= in_mac;
      now_r     <= in_now;
      max_age_r <= in_max_age;
    end
    if (cmd.scan_clear) begin
      idx_r <= '0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.scan_step && hit_now && !hit_r) begin
      hit_idx_r <= idx_r;
    end
    if (cmd.scan_step && !valid_r[idx_r] && !free_r) begin
      free_idx_r <= idx_r;
    end
    if (cmd.age) begin
      diff_r <= now_r - stamp_mem[hit_idx_r];
    end
    if (cmd.write) begin
      ip_mem[wr_idx]    <= ip_r;
      mac_mem[wr_idx]   <= mac_r;
      stamp_mem[wr_idx] <= now_r;
    end
    if (cmd.emit) begin
      out_outcome_r <= cmd.outcome;
      out_mac_r     <= res_mac;
      out_slot_r    <= res_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.flush) begin
        valid_r <= '0;
      end else if (cmd.write) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (cmd.scan_clear) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (cmd.scan_step) begin
        if (hit_now) begin
          hit_r <= 1'b1;
        end
        if (!valid_r[idx_r]) begin
          free_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_outcome = out_outcome_r;
  assign out_mac     = out_mac_r;
  assign out_slot    = out_slot_r;

endmodule

/* design/address_resolution_cache.sv */
// Address resolution cache: eight-slot fully associative IPv4 -> MAC table.
// Input channel (in_*): one word per operation. tuser holds the kind (lookup,
// store, flush); tdata holds address, MAC, current tick and max age.
// Output channel (out_*): exactly one result word per input word, in order.
// tuser holds the outcome code, tdata the MAC (hits only) and the slot.
// Steps: a decode state follows the accept edge, then the match scan walks
// the table one slot per cycle (up to 8), a lookup hit adds the age and
// check states for the 64-bit age subtract and compare, a store adds a
// write state, and the emit state loads the result register. Flush, zero
// address and unused kind skip the scan. The next word is taken only once
// the previous result is loaded.
// in_tready is high only while the controller is idle: one word at a time.
// The result register lets the next word be accepted while a result still
// waits; a stalled receiver holds the controller before its next result.
// Reset (synchronous, rst_n low) clears all valid bits and out_tvalid and returns the controller to idle.
module address_resolution_cache (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [207:0]              in_tdata,  // ip_addr[31:0], mac_in[79:32],
                                               // now_tick[143:80], max_age[207:144]
  input  logic [1:0]                in_tuser,  // kind[1:0]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [55:0]               out_tdata, // mac_out[47:0], slot[50:48], zero
  output logic [2:0]                out_tuser  // outcome[2:0]
);
  import arc_pkg::*;

  arc_cmd_t  cmd;
  arc_stat_t stat;
  outcome_t  res_outcome;
  logic [MAC_W-1:0]  res_mac;
  logic [SLOT_W-1:0] res_slot;

  arc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  arc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_kind     (kind_t'(in_tuser)),
    .in_ip       (in_tdata[31:0]),
    .in_mac      (in_tdata[79:32]),
    .in_now      (in_tdata[143:80]),
    .in_max_age  (in_tdata[207:144]),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_outcome (res_outcome),
    .out_mac     (res_mac),
    .out_slot    (res_slot)
  );

  assign out_tuser = res_outcome;
  assign out_tdata = {5'd0, res_slot, res_mac};

endmodule
